>>> src/ldbf_pkg.sv
`timescale 1ns / 1ps
package ldbf_pkg;
    localparam int POINT_COUNT_DEF = 1024;
    localparam int GAP_DEPTH_DEF   = 256;
    localparam logic [16:0] ONE   = 17'd65536;
    localparam logic [16:0] HALF  = 17'd32768;
    localparam logic [16:0] FLOOR = 17'd3277;
    localparam logic [16:0] HIGH_P = 17'd52429;
    localparam logic [16:0] HIGH_U = 17'd19660;
    localparam logic [63:0] RATIO_P = 64'd4085499269;
    localparam logic [63:0] RATIO_U = 64'd4168031830;

    localparam logic [1:0] ST_STATIC    = 2'd0;
    localparam logic [1:0] ST_RECOVERED = 2'd1;
    localparam logic [1:0] ST_DYNAMIC   = 2'd2;

    localparam logic [1:0] MODE_RAW     = 2'd0;
    localparam logic [1:0] MODE_PERSIST = 2'd1;
    localparam logic [1:0] MODE_CLEAN   = 2'd2;

    localparam logic [2:0] REG_BELIEF = 3'd0;
    localparam logic [2:0] REG_GAP    = 3'd1;
    localparam logic [2:0] REG_UNC_EN = 3'd2;
    localparam logic [2:0] REG_MODE   = 3'd3;
    localparam logic [2:0] REG_REL    = 3'd4;
    localparam logic [2:0] REG_INIT_U = 3'd5;

    typedef struct packed {
        logic       belief_enable;
        logic       gap_decay_enable;
        logic       uncertainty_enable;
        logic [1:0] uncertainty_mode;
        logic       reliability_enable;
        logic [16:0] initial_uncertainty;
    } cfg_t;

    // controller to datapath
    typedef struct packed {
        logic load;
        logic clear;
        logic read;
        logic calc1;
        logic calc2;
        logic calc3;
        logic write;
    } cmd_t;

    // decay table entry g, evaluated at elaboration (constant argument)
    function automatic logic [16:0] decay_entry(input int g, input logic [63:0] ratio);
        logic [63:0] acc;
        acc = 64'd1 << 32;
        for (int i = 0; i < g; i++) begin
            acc = 64'((({64'd0, acc} * {64'd0, ratio}) + 128'h80000000) >> 32);
        end
        return 17'((acc + 64'h8000) >> 16);
    endfunction
endpackage

>>> src/ldbf_ctrl.sv
`timescale 1ns / 1ps
module ldbf_ctrl (
    input  logic          aclk,
    input  logic          aresetn,
    input  logic          in_fire,
    input  logic          in_range,
    input  logic          clear_last,
    input  logic          out_free,
    output logic          s_ready,
    output ldbf_pkg::cmd_t cmd
);
    localparam logic [2:0] S_CLEAR = 3'd0;
    localparam logic [2:0] S_IDLE  = 3'd1;
    localparam logic [2:0] S_READ  = 3'd2;
    localparam logic [2:0] S_C1    = 3'd3;
    localparam logic [2:0] S_C2    = 3'd4;
    localparam logic [2:0] S_C3    = 3'd5;
    localparam logic [2:0] S_WR    = 3'd6;

    logic [2:0] state_reg, state_next;

    assign s_ready = (state_reg == S_IDLE);

    // sequencer
    always_comb begin
        state_next = state_reg;
        cmd = '0;
        unique case (state_reg)
            S_CLEAR: begin
                cmd.clear = 1'b1;
                if (clear_last) state_next = S_IDLE;
            end
            S_IDLE: begin
                cmd.load = in_fire;
                if (in_fire && in_range) state_next = S_READ;
            end
            S_READ: begin cmd.read = 1'b1; state_next = S_C1; end
            S_C1:   begin cmd.calc1 = 1'b1; state_next = S_C2; end
            S_C2:   begin cmd.calc2 = 1'b1; state_next = S_C3; end
            S_C3:   begin cmd.calc3 = 1'b1; state_next = S_WR; end
            S_WR: begin
                if (out_free) begin
                    cmd.write = 1'b1;
                    state_next = S_IDLE;
                end
            end
            default: state_next = S_IDLE;
        endcase
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) state_reg <= S_CLEAR;
        else state_reg <= state_next;
    end

    a_write_after_calc: assert property (@(posedge aclk) disable iff (!aresetn)
        cmd.write |-> state_reg == S_WR) else $error("write outside write state");
    a_no_accept_clear: assert property (@(posedge aclk) disable iff (!aresetn)
        cmd.clear |-> !s_ready) else $error("ready during clear");
    a_read_follows: assert property (@(posedge aclk) disable iff (!aresetn)
        cmd.read |=> cmd.calc1) else $error("calc does not follow read");
endmodule

>>> src/ldbf_datapath.sv
`timescale 1ns / 1ps
module ldbf_datapath #(
    parameter int POINT_COUNT = ldbf_pkg::POINT_COUNT_DEF,
    parameter int GAP_DEPTH   = ldbf_pkg::GAP_DEPTH_DEF,
    parameter int IDX_W       = 10
) (
    input  logic             aclk,
    input  logic             aresetn,
    input  ldbf_pkg::cmd_t   cmd,
    input  ldbf_pkg::cfg_t   cfg,
    input  logic [IDX_W-1:0] s_point_index,
    input  logic [15:0]      s_owner_object,
    input  logic [1:0]       s_observed_status,
    input  logic [31:0]      s_frame_number,
    output logic             in_range,
    output logic             clear_last,
    output logic             out_free,
    input  logic             m_ready,
    output logic             m_valid,
    output logic [16:0]      m_motion_probability,
    output logic [16:0]      m_uncertainty_level,
    output logic [16:0]      m_reliability,
    output logic [16:0]      m_conflict_level,
    output logic             m_is_dynamic,
    output logic             m_high_confidence,
    output logic [15:0]      m_record_owner,
    output logic [1:0]       m_record_status
);
    localparam int AW = (POINT_COUNT > 1) ? $clog2(POINT_COUNT) : 1;
    localparam int GW = $clog2(GAP_DEPTH);
    // entry: valid, seen, lastbit, p, u, pers, frame, owner, status
    localparam int EW = 3 + 17 * 3 + 32 + 18;

    logic [EW-1:0] mem [POINT_COUNT];
    logic [EW-1:0] rd_reg;
    logic [AW-1:0] clr_reg;
    logic [AW-1:0] idx_reg;
    logic [15:0]   own_reg;
    logic [1:0]    st_reg;
    logic [31:0]   frm_reg;

    logic [16:0] ep_tab [GAP_DEPTH];
    logic [16:0] eu_tab [GAP_DEPTH];
    for (genvar g = 0; g < GAP_DEPTH; g++) begin : g_tab
        assign ep_tab[g] = ldbf_pkg::decay_entry(g, ldbf_pkg::RATIO_P);
        assign eu_tab[g] = ldbf_pkg::decay_entry(g, ldbf_pkg::RATIO_U);
    end

    function automatic logic [16:0] qmul(input logic [16:0] a, input logic [16:0] b);
        logic [33:0] pr;
        pr = a * b + 34'd32768;
        return pr[32:16];
    endfunction

    assign in_range = ({{(32-IDX_W){1'b0}}, s_point_index} < 32'(POINT_COUNT));
    assign clear_last = (clr_reg == AW'(POINT_COUNT - 1));
    assign out_free = !m_valid || m_ready;

    // unpack read entry
    logic        r_valid, r_seen, r_bit;
    logic [16:0] r_p, r_u, r_pers;
    logic [31:0] r_frame;
    logic [15:0] r_own;
    logic [1:0]  r_st;
    assign {r_valid, r_seen, r_bit, r_p, r_u, r_pers, r_frame, r_own, r_st} = rd_reg;

    logic obs;
    assign obs = (st_reg == ldbf_pkg::ST_DYNAMIC);

    logic [16:0] init_u;
    assign init_u = cfg.initial_uncertainty > ldbf_pkg::ONE ? ldbf_pkg::ONE
                                                            : cfg.initial_uncertainty;

    // stage 1: gap, decay index, start values, persistence
    logic [16:0] p0_reg, u0_reg, pers_reg;
    logic [GW-1:0] gi_reg;
    logic [31:0] gap;
    logic [16:0] pers_n;
    logic [19:0] pers_sum;
    logic [39:0] pers_prod;
    always_comb begin
        gap = (r_seen && (frm_reg > r_frame)) ? frm_reg - r_frame - 32'd1 : 32'd0;
        pers_sum = 20'((r_seen ? r_pers : 17'd0)) * 20'd4
                 + ((r_seen && (obs != r_bit)) ? 20'd65536 : 20'd0) + 20'd2;
        // divide by 5: multiply by ceil(2^22/5), exact below 2^22
        pers_prod = 40'(pers_sum) * 40'd838861;
        pers_n = pers_prod[38:22];
    end

    // stage 2: decay
    logic [16:0] p1_reg, u1_reg;
    // stage 3: raw conflict and its persistent form
    logic [16:0] raw_reg, p2_reg, u2_reg;
    logic [16:0] pc;
    assign pc = qmul(raw_reg, pers_reg);

    // final belief
    logic [16:0] p_f, u_f, term, rel_f;
    logic [20:0] psum;
    logic [19:0] usum;
    logic [40:0] psum_prod;
    logic [39:0] usum_prod;
    logic        dyn_f, hc_f, repl;
    logic [15:0] own_f;
    logic [1:0]  st_f;
    always_comb begin
        psum = 21'(p1_reg) * 21'd7 + (obs ? 21'd196608 : 21'd0) + 21'd5;
        term = (cfg.uncertainty_mode == ldbf_pkg::MODE_PERSIST) ? pc :
               (cfg.uncertainty_mode == ldbf_pkg::MODE_CLEAN) ? 17'd0 : raw_reg;
        usum = 20'(u1_reg) * 20'd4 + 20'(term) + 20'd2;
        // divide by 10 with ceil(2^23/10), by 5 with ceil(2^22/5)
        psum_prod = 41'(psum) * 41'd838861;
        usum_prod = 40'(usum) * 40'd838861;
        if (!cfg.belief_enable) begin
            p_f = obs ? ldbf_pkg::ONE : 17'd0;
            u_f = 17'd0;
        end else begin
            p_f = psum_prod[39:23];
            if (cfg.uncertainty_enable) begin
                u_f = usum_prod[38:22];
                if (u_f < ldbf_pkg::FLOOR) u_f = ldbf_pkg::FLOOR;
                if (u_f > ldbf_pkg::ONE) u_f = ldbf_pkg::ONE;
            end else begin
                u_f = 17'd0;
            end
        end
        repl = !r_valid || ((r_seen ? r_frame : 32'd0) != frm_reg) || (st_reg > r_st)
             || ((st_reg == r_st) && (own_reg < r_own));
        own_f = repl ? own_reg : r_own;
        st_f = repl ? st_reg : r_st;
    end

    // stage 4: reliability from registered p and u
    always_comb begin
        rel_f = qmul(ldbf_pkg::ONE - p2_reg, ldbf_pkg::ONE - u2_reg);
        if (!cfg.reliability_enable) rel_f = ldbf_pkg::ONE;
        else if (rel_f < ldbf_pkg::FLOOR) rel_f = ldbf_pkg::FLOOR;
        if (!cfg.belief_enable) begin
            dyn_f = (m_record_status == ldbf_pkg::ST_DYNAMIC);
            hc_f = dyn_f;
        end else begin
            dyn_f = p2_reg > ldbf_pkg::HALF;
            hc_f = (p2_reg >= ldbf_pkg::HIGH_P) &&
                   (!cfg.uncertainty_enable || u2_reg <= ldbf_pkg::HIGH_U);
        end
    end

    always_ff @(posedge aclk) begin
        // input capture, status 3 treated as static
        if (cmd.load) begin
            idx_reg <= AW'(s_point_index);
            own_reg <= s_owner_object;
            st_reg  <= (s_observed_status == 2'd3) ? ldbf_pkg::ST_STATIC : s_observed_status;
            frm_reg <= s_frame_number;
        end
        if (cmd.read) rd_reg <= mem[idx_reg];
        if (cmd.calc1) begin
            p0_reg <= r_seen ? r_p : 17'd0;
            u0_reg <= r_seen ? r_u : init_u;
            pers_reg <= pers_n;
            gi_reg <= (gap > 32'(GAP_DEPTH - 1)) ? GW'(GAP_DEPTH - 1) : GW'(gap);
        end
        if (cmd.calc2) begin
            if (cfg.belief_enable && cfg.gap_decay_enable) begin
                p1_reg <= qmul(p0_reg, ep_tab[gi_reg]);
                u1_reg <= cfg.uncertainty_enable ?
                          ldbf_pkg::ONE - qmul(ldbf_pkg::ONE - u0_reg, eu_tab[gi_reg]) : u0_reg;
            end else begin
                p1_reg <= p0_reg;
                u1_reg <= u0_reg;
            end
        end
        if (cmd.calc3) begin
            raw_reg <= qmul(obs ? ldbf_pkg::ONE - p1_reg : p1_reg, ldbf_pkg::ONE - u1_reg);
        end
        if (cmd.clear) mem[clr_reg] <= '0;
        else if (cmd.write) begin
            mem[idx_reg] <= {1'b1, 1'b1, obs, p_f, u_f, pers_reg, frm_reg, own_f, st_f};
            p2_reg <= p_f;
            u2_reg <= u_f;
            m_motion_probability <= p_f;
            m_uncertainty_level <= u_f;
            m_conflict_level <= raw_reg;
            m_record_owner <= own_f;
            m_record_status <= st_f;
        end
    end

    // result flags registered in the cycle after the write; valid raised with them
    logic flag_pend_reg;
    always_ff @(posedge aclk) begin
        if (flag_pend_reg) begin
            m_reliability <= rel_f;
            m_is_dynamic <= dyn_f;
            m_high_confidence <= hc_f;
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            clr_reg <= '0;
            flag_pend_reg <= 1'b0;
            m_valid <= 1'b0;
        end else begin
            if (cmd.clear) clr_reg <= clr_reg + AW'(1);
            flag_pend_reg <= cmd.write;
            if (flag_pend_reg) m_valid <= 1'b1;
            else if (m_ready) m_valid <= 1'b0;
        end
    end

    a_valid_hold: assert property (@(posedge aclk) disable iff (!aresetn)
        m_valid && !m_ready |=> m_valid) else $error("result dropped");
    a_write_free: assert property (@(posedge aclk) disable iff (!aresetn)
        cmd.write |-> !flag_pend_reg) else $error("result overrun");
    a_u_range: assert property (@(posedge aclk) disable iff (!aresetn)
        m_valid |-> m_uncertainty_level <= ldbf_pkg::ONE) else $error("u out of range");
endmodule

>>> src/landmark_dynamic_belief_filter.sv
`timescale 1ns / 1ps
// landmark dynamic belief filter
// input channel s_*: one landmark observation per transaction (point index,
// owner object, observed status, frame number); result channel m_*: one
// transaction per observation with the updated belief, reliability, flags
// and the recorded owner and status. indexes at or beyond POINT_COUNT are
// dropped without a result.
// an accepted observation is read from the belief store, goes through gap
// decay, conflict and smoothing steps of a fixed sequencer and is written
// back; the next item is taken only after write-back, once the sequencer
// is back in idle, so observations are not overlapped. the chained
// multiplies on the single store read/write port set this pace.
// after reset the store is swept clear, one entry a cycle, with s_ready
// low; registers can be written meanwhile over apb.
// if the receiver stalls, the result is held and the next write-back waits.
module landmark_dynamic_belief_filter #(
    parameter int POINT_COUNT     = ldbf_pkg::POINT_COUNT_DEF,
    parameter int GAP_TABLE_DEPTH = ldbf_pkg::GAP_DEPTH_DEF
) (
    input  logic        aclk,
    input  logic        aresetn,
    input  logic        psel,
    input  logic        penable,
    input  logic        pwrite,
    input  logic [4:0]  paddr,
    input  logic [31:0] pwdata,
    output logic [31:0] prdata,
    output logic        pready,
    input  logic        s_valid,
    output logic        s_ready,
    input  logic [9:0]  s_point_index,
    input  logic [15:0] s_owner_object,
    input  logic [1:0]  s_observed_status,
    input  logic [31:0] s_frame_number,
    output logic        m_valid,
    input  logic        m_ready,
    output logic [16:0] m_motion_probability,
    output logic [16:0] m_uncertainty_level,
    output logic [16:0] m_reliability,
    output logic [16:0] m_conflict_level,
    output logic        m_is_dynamic,
    output logic        m_high_confidence,
    output logic [15:0] m_record_owner,
    output logic [1:0]  m_record_status
);
    ldbf_pkg::cfg_t cfg_reg;
    ldbf_pkg::cmd_t cmd;
    logic in_range, clear_last, out_free;
    logic [2:0] ridx;
    assign ridx = paddr[4:2];
    assign pready = 1'b1;

    // register writes
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            cfg_reg <= '{1'b1, 1'b1, 1'b1, ldbf_pkg::MODE_RAW, 1'b1, ldbf_pkg::ONE};
        end else if (psel && penable && pwrite) begin
            unique case (ridx)
                ldbf_pkg::REG_BELIEF: cfg_reg.belief_enable <= pwdata[0];
                ldbf_pkg::REG_GAP:    cfg_reg.gap_decay_enable <= pwdata[0];
                ldbf_pkg::REG_UNC_EN: cfg_reg.uncertainty_enable <= pwdata[0];
                ldbf_pkg::REG_MODE:   cfg_reg.uncertainty_mode <= pwdata[1:0];
                ldbf_pkg::REG_REL:    cfg_reg.reliability_enable <= pwdata[0];
                ldbf_pkg::REG_INIT_U: cfg_reg.initial_uncertainty <= pwdata[16:0];
                default: ;
            endcase
        end
    end

    // register reads
    always_comb begin
        prdata = '0;
        unique case (ridx)
            ldbf_pkg::REG_BELIEF: prdata[0] = cfg_reg.belief_enable;
            ldbf_pkg::REG_GAP:    prdata[0] = cfg_reg.gap_decay_enable;
            ldbf_pkg::REG_UNC_EN: prdata[0] = cfg_reg.uncertainty_enable;
            ldbf_pkg::REG_MODE:   prdata[1:0] = cfg_reg.uncertainty_mode;
            ldbf_pkg::REG_REL:    prdata[0] = cfg_reg.reliability_enable;
            ldbf_pkg::REG_INIT_U: prdata[16:0] = cfg_reg.initial_uncertainty;
            default: prdata = '0;
        endcase
    end

    ldbf_ctrl u_ctrl (
        .aclk(aclk), .aresetn(aresetn), .in_fire(s_valid && s_ready),
        .in_range(in_range), .clear_last(clear_last), .out_free(out_free),
        .s_ready(s_ready), .cmd(cmd)
    );

    ldbf_datapath #(.POINT_COUNT(POINT_COUNT), .GAP_DEPTH(GAP_TABLE_DEPTH), .IDX_W(10)) u_dp (
        .aclk(aclk), .aresetn(aresetn), .cmd(cmd), .cfg(cfg_reg),
        .s_point_index(s_point_index), .s_owner_object(s_owner_object),
        .s_observed_status(s_observed_status), .s_frame_number(s_frame_number),
        .in_range(in_range), .clear_last(clear_last), .out_free(out_free),
        .m_ready(m_ready), .m_valid(m_valid),
        .m_motion_probability(m_motion_probability),
        .m_uncertainty_level(m_uncertainty_level), .m_reliability(m_reliability),
        .m_conflict_level(m_conflict_level), .m_is_dynamic(m_is_dynamic),
        .m_high_confidence(m_high_confidence), .m_record_owner(m_record_owner),
        .m_record_status(m_record_status)
    );
endmodule

>>> dv/tb_landmark_dynamic_belief_filter.sv
`timescale 1ns / 1ps
module tb_landmark_dynamic_belief_filter;
    localparam int NPTS      = 1024;
    localparam int GAP_DEPTH = 256;
    localparam int LIMIT     = 600000;
    localparam int PER_PHASE = 310;

    typedef struct packed {
        logic [16:0] prob;
        logic [16:0] unc;
        logic [16:0] rel;
        logic [16:0] conflict;
        logic        dyn;
        logic        hconf;
        logic [15:0] owner;
        logic [1:0]  status;
    } belief_out_t;

    typedef struct {
        logic [9:0]  idx;
        logic [15:0] owner;
        logic [1:0]  status;
        logic [31:0] frame;
        bit          typed;
        logic [16:0] prob;
        logic [16:0] unc;
        logic [16:0] rel;
        logic [16:0] conflict;
    } obs_row_t;

    logic aclk = 1'b0;
    logic aresetn = 1'b0;
    logic psel = 1'b0, penable = 1'b0, pwrite = 1'b0;
    logic [4:0] paddr = '0;
    logic [31:0] pwdata = '0;
    logic [31:0] prdata;
    logic pready;
    logic s_valid = 1'b0;
    logic s_ready;
    logic [9:0] s_point_index = '0;
    logic [15:0] s_owner_object = '0;
    logic [1:0] s_observed_status = '0;
    logic [31:0] s_frame_number = '0;
    logic m_valid;
    logic m_ready = 1'b0;
    logic [16:0] m_motion_probability, m_uncertainty_level, m_reliability, m_conflict_level;
    logic m_is_dynamic, m_high_confidence;
    logic [15:0] m_record_owner;
    logic [1:0] m_record_status;

    landmark_dynamic_belief_filter uut (.*);

    // clock
    always begin
        #5 aclk = 1'b1;
        #5 aclk = 1'b0;
    end

    // shadow configuration
    bit        cf_belief, cf_gap, cf_unc, cf_rel;
    bit [1:0]  cf_mode;
    bit [16:0] cf_init_u;

    // shadow belief store
    bit        pt_valid [NPTS];
    bit        pt_seen [NPTS];
    bit [63:0] pt_prob [NPTS];
    bit [63:0] pt_unc [NPTS];
    bit [63:0] pt_persist [NPTS];
    bit        pt_last_obs [NPTS];
    bit [31:0] pt_last_frame [NPTS];
    bit [15:0] pt_owner [NPTS];
    bit [1:0]  pt_status [NPTS];
    bit [63:0] decay_prob_tab [GAP_DEPTH];
    bit [63:0] decay_unc_tab [GAP_DEPTH];

    belief_out_t pending_beliefs[$];
    bit failed = 1'b0;
    int unsigned cycle_count = 0;
    int send_idle_pct = 0, recv_idle_pct = 0;
    bit [31:0] next_frame [NPTS];

    function automatic bit [63:0] qmul(bit [63:0] a, bit [63:0] b);
        return (a * b + 64'd32768) >> 16;
    endfunction

    // exponential decay tables per missed-frame count
    initial begin
        bit [127:0] acc_p, acc_u;
        acc_p = 128'd1 << 32;
        acc_u = 128'd1 << 32;
        for (int g = 0; g < GAP_DEPTH; g++) begin
            decay_prob_tab[g] = 64'((acc_p + 128'h8000) >> 16);
            decay_unc_tab[g] = 64'((acc_u + 128'h8000) >> 16);
            acc_p = (acc_p * 128'(ldbf_pkg::RATIO_P) + 128'h80000000) >> 32;
            acc_u = (acc_u * 128'(ldbf_pkg::RATIO_U) + 128'h80000000) >> 32;
        end
    end

    // belief update for one accepted observation
    function automatic belief_out_t update_belief(bit [9:0] k, bit [15:0] owner,
                                                  bit [1:0] status_in, bit [31:0] frame);
        belief_out_t r;
        bit [63:0] p, u, pers, raw, pc, term, rel, gi, one;
        bit [31:0] gap, prevf;
        bit [1:0] status;
        bit obs, sw, seen, dyn, hc;
        one = 64'(ldbf_pkg::ONE);
        status = (status_in == 2'd3) ? ldbf_pkg::ST_STATIC : status_in;
        obs = (status == ldbf_pkg::ST_DYNAMIC);
        seen = pt_seen[k];
        if (seen) begin
            p = pt_prob[k];
            u = pt_unc[k];
            pers = pt_persist[k];
        end else begin
            p = 64'd0;
            u = (cf_init_u > ldbf_pkg::ONE) ? one : 64'(cf_init_u);
            pers = 64'd0;
        end
        prevf = seen ? pt_last_frame[k] : 32'd0;
        gap = (seen && frame > prevf) ? frame - prevf - 32'd1 : 32'd0;
        // decay over missed frames
        if (cf_belief && cf_gap) begin
            gi = (gap > 32'(GAP_DEPTH - 1)) ? 64'(GAP_DEPTH - 1) : 64'(gap);
            p = qmul(p, decay_prob_tab[gi]);
            if (cf_unc) u = one - qmul(one - u, decay_unc_tab[gi]);
        end
        // conflict and switch persistence
        sw = seen && (obs != pt_last_obs[k]);
        pers = (64'd4 * pers + (sw ? one : 64'd0) + 64'd2) / 64'd5;
        raw = qmul(obs ? one - p : p, one - u);
        pc = qmul(raw, pers);
        // smoothing
        if (!cf_belief) begin
            p = obs ? one : 64'd0;
            u = 64'd0;
        end else begin
            p = (64'd7 * p + (obs ? 64'd3 * one : 64'd0) + 64'd5) / 64'd10;
            if (cf_unc) begin
                term = (cf_mode == ldbf_pkg::MODE_PERSIST) ? pc :
                       (cf_mode == ldbf_pkg::MODE_CLEAN) ? 64'd0 : raw;
                u = (64'd4 * u + term + 64'd2) / 64'd5;
                if (u < 64'(ldbf_pkg::FLOOR)) u = 64'(ldbf_pkg::FLOOR);
                if (u > one) u = one;
            end else begin
                u = 64'd0;
            end
        end
        // owner record by priority
        if (!pt_valid[k] || prevf != frame || status > pt_status[k] ||
            (status == pt_status[k] && owner < pt_owner[k])) begin
            pt_owner[k] = owner;
            pt_status[k] = status;
        end
        pt_prob[k] = p;
        pt_unc[k] = u;
        pt_persist[k] = pers;
        pt_last_obs[k] = obs;
        pt_seen[k] = 1'b1;
        pt_last_frame[k] = frame;
        pt_valid[k] = 1'b1;
        if (!cf_rel) begin
            rel = one;
        end else begin
            rel = qmul(one - p, one - u);
            if (rel < 64'(ldbf_pkg::FLOOR)) rel = 64'(ldbf_pkg::FLOOR);
        end
        if (!cf_belief) begin
            dyn = (pt_status[k] == ldbf_pkg::ST_DYNAMIC);
            hc = dyn;
        end else begin
            dyn = p > 64'(ldbf_pkg::HALF);
            hc = (p >= 64'(ldbf_pkg::HIGH_P)) && (!cf_unc || u <= 64'(ldbf_pkg::HIGH_U));
        end
        r.prob = p[16:0];
        r.unc = u[16:0];
        r.rel = rel[16:0];
        r.conflict = raw[16:0];
        r.dyn = dyn;
        r.hconf = hc;
        r.owner = pt_owner[k];
        r.status = pt_status[k];
        return r;
    endfunction

    // register write, setup then access
    task automatic write_reg(logic [2:0] regno, logic [31:0] val);
        @(posedge aclk);
        psel <= 1'b1;
        penable <= 1'b0;
        pwrite <= 1'b1;
        paddr <= {regno, 2'b00};
        pwdata <= val;
        @(posedge aclk);
        penable <= 1'b1;
        @(posedge aclk);
        psel <= 1'b0;
        penable <= 1'b0;
        pwrite <= 1'b0;
        case (regno)
            ldbf_pkg::REG_BELIEF: cf_belief = val[0];
            ldbf_pkg::REG_GAP:    cf_gap = val[0];
            ldbf_pkg::REG_UNC_EN: cf_unc = val[0];
            ldbf_pkg::REG_MODE:   cf_mode = val[1:0];
            ldbf_pkg::REG_REL:    cf_rel = val[0];
            ldbf_pkg::REG_INIT_U: cf_init_u = val[16:0];
            default: ;
        endcase
    endtask

    task automatic write_all(bit be, bit ge, bit ue, bit [1:0] md, bit re, bit [16:0] iu);
        write_reg(ldbf_pkg::REG_BELIEF, 32'(be));
        write_reg(ldbf_pkg::REG_GAP, 32'(ge));
        write_reg(ldbf_pkg::REG_UNC_EN, 32'(ue));
        write_reg(ldbf_pkg::REG_MODE, 32'(md));
        write_reg(ldbf_pkg::REG_REL, 32'(re));
        write_reg(ldbf_pkg::REG_INIT_U, 32'(iu));
    endtask

    // send one observation, holding it until accepted
    task automatic send_obs(obs_row_t row);
        belief_out_t want;
        while ($urandom_range(0, 99) < send_idle_pct) begin
            s_valid <= 1'b0;
            @(posedge aclk);
        end
        s_valid <= 1'b1;
        s_point_index <= row.idx;
        s_owner_object <= row.owner;
        s_observed_status <= row.status;
        s_frame_number <= row.frame;
        do @(posedge aclk); while (!s_ready);
        want = update_belief(row.idx, row.owner, row.status, row.frame);
        if (row.typed) begin
            want.prob = row.prob;
            want.unc = row.unc;
            want.rel = row.rel;
            want.conflict = row.conflict;
        end
        pending_beliefs.push_back(want);
        if (row.frame >= next_frame[row.idx]) next_frame[row.idx] = row.frame + 32'd1;
    endtask

    task automatic drain();
        s_valid <= 1'b0;
        while (pending_beliefs.size() != 0) @(posedge aclk);
        repeat (20) @(posedge aclk);
    endtask

    function automatic obs_row_t rand_obs();
        obs_row_t row;
        int sel;
        bit [9:0] k;
        row.typed = 1'b0;
        sel = $urandom_range(0, 99);
        row.owner = ($urandom_range(0, 1) == 1) ? 16'($urandom) : 16'($urandom_range(0, 3));
        row.status = 2'($urandom_range(0, 3));
        if (sel < 85) begin
            // revisit a small set of points with mostly advancing frames
            k = 10'($urandom_range(0, 23));
            row.idx = k;
            case ($urandom_range(0, 9))
                0, 1:    row.frame = next_frame[k] - 32'd1;
                2:       row.frame = next_frame[k] + $urandom_range(1, 12);
                3:       row.frame = next_frame[k] + $urandom_range(200, 600);
                4:       row.frame = next_frame[k] - $urandom_range(2, 20);
                default: row.frame = next_frame[k];
            endcase
        end else begin
            row.idx = 10'($urandom);
            row.frame = $urandom;
        end
        return row;
    endfunction

    // result checking and receiver stalls
    always @(posedge aclk) begin
        belief_out_t want;
        if (aresetn && m_valid && m_ready) begin
            if (pending_beliefs.size() == 0) begin
                $error("unexpected result transaction");
                failed = 1'b1;
            end else begin
                want = pending_beliefs.pop_front();
                if (m_motion_probability !== want.prob) begin
                    $error("motion_probability exp %0d got %0d", want.prob,
                           m_motion_probability);
                    failed = 1'b1;
                end
                if (m_uncertainty_level !== want.unc) begin
                    $error("uncertainty_level exp %0d got %0d", want.unc, m_uncertainty_level);
                    failed = 1'b1;
                end
                if (m_reliability !== want.rel) begin
                    $error("reliability exp %0d got %0d", want.rel, m_reliability);
                    failed = 1'b1;
                end
                if (m_conflict_level !== want.conflict) begin
                    $error("conflict_level exp %0d got %0d", want.conflict, m_conflict_level);
                    failed = 1'b1;
                end
                if (m_is_dynamic !== want.dyn) begin
                    $error("is_dynamic exp %0d got %0d", want.dyn, m_is_dynamic);
                    failed = 1'b1;
                end
                if (m_high_confidence !== want.hconf) begin
                    $error("high_confidence exp %0d got %0d", want.hconf, m_high_confidence);
                    failed = 1'b1;
                end
                if (m_record_owner !== want.owner) begin
                    $error("record_owner exp %0d got %0d", want.owner, m_record_owner);
                    failed = 1'b1;
                end
                if (m_record_status !== want.status) begin
                    $error("record_status exp %0d got %0d", want.status, m_record_status);
                    failed = 1'b1;
                end
            end
        end
        m_ready <= ($urandom_range(0, 99) >= recv_idle_pct);
    end

    // watchdog
    always @(posedge aclk) begin
        cycle_count <= cycle_count + 1;
        if (cycle_count > LIMIT) begin
            $display("landmark_dynamic_belief_filter verification failed");
            $finish;
        end
    end

    // directed observations; first row checked by hand against reset state
    obs_row_t directed [] = '{
        '{10'd0,    16'd0,     ldbf_pkg::ST_STATIC,    32'd0,        1'b1, 17'd0, 17'd52429,
          17'd13107, 17'd0},
        '{10'd0,    16'd5,     ldbf_pkg::ST_STATIC,    32'd0,        1'b0, 0, 0, 0, 0},
        '{10'd0,    16'd3,     ldbf_pkg::ST_STATIC,    32'd0,        1'b0, 0, 0, 0, 0},
        '{10'd0,    16'd9,     ldbf_pkg::ST_RECOVERED, 32'd0,        1'b0, 0, 0, 0, 0},
        '{10'd0,    16'd1,     ldbf_pkg::ST_DYNAMIC,   32'd0,        1'b0, 0, 0, 0, 0},
        '{10'd0,    16'hFFFF,  ldbf_pkg::ST_DYNAMIC,   32'd1,        1'b0, 0, 0, 0, 0},
        '{10'd0,    16'd7,     ldbf_pkg::ST_DYNAMIC,   32'd2,        1'b0, 0, 0, 0, 0},
        '{10'd0,    16'd7,     ldbf_pkg::ST_DYNAMIC,   32'd3,        1'b0, 0, 0, 0, 0},
        '{10'd0,    16'd7,     ldbf_pkg::ST_DYNAMIC,   32'd4,        1'b0, 0, 0, 0, 0},
        '{10'd0,    16'd7,     ldbf_pkg::ST_STATIC,    32'd9,        1'b0, 0, 0, 0, 0},
        '{10'd0,    16'd7,     ldbf_pkg::ST_DYNAMIC,   32'd1000,     1'b0, 0, 0, 0, 0},
        '{10'd0,    16'd7,     2'd3,                   32'd500,      1'b0, 0, 0, 0, 0},
        '{10'd1023, 16'hFFFF,  ldbf_pkg::ST_DYNAMIC,   32'hFFFFFFFF, 1'b0, 0, 0, 0, 0},
        '{10'd1023, 16'd0,     ldbf_pkg::ST_DYNAMIC,   32'hFFFFFFFF, 1'b0, 0, 0, 0, 0},
        '{10'd1023, 16'd2,     2'd3,                   32'd0,        1'b0, 0, 0, 0, 0},
        '{10'd512,  16'h8000,  ldbf_pkg::ST_RECOVERED, 32'd257,      1'b0, 0, 0, 0, 0},
        '{10'd512,  16'h8000,  ldbf_pkg::ST_RECOVERED, 32'd300,      1'b0, 0, 0, 0, 0},
        '{10'd341,  16'h5555,  ldbf_pkg::ST_DYNAMIC,   32'hAAAAAAAA, 1'b0, 0, 0, 0, 0},
        '{10'd682,  16'hAAAA,  ldbf_pkg::ST_STATIC,    32'h55555555, 1'b0, 0, 0, 0, 0}
    };

    // main sequence
    initial begin
        cf_belief = 1'b1;
        cf_gap = 1'b1;
        cf_unc = 1'b1;
        cf_mode = ldbf_pkg::MODE_RAW;
        cf_rel = 1'b1;
        cf_init_u = ldbf_pkg::ONE;
        repeat (11) @(posedge aclk);
        aresetn <= 1'b1;

        send_idle_pct = 11;
        recv_idle_pct = 85;
        foreach (directed[i]) send_obs(directed[i]);

        for (int ph = 0; ph < 6; ph++) begin
            drain();
            send_idle_pct = (ph < 2) ? 11 : (ph < 4) ? 85 : 0;
            recv_idle_pct = (ph < 2) ? 85 : (ph < 4) ? 11 : 0;
            case (ph)
                0: write_all(1'b1, 1'b1, 1'b1, ldbf_pkg::MODE_PERSIST, 1'b1, 17'd0);
                1: write_all(1'b1, 1'b1, 1'b1, ldbf_pkg::MODE_CLEAN, 1'b0, 17'h1FFFF);
                2: write_all(1'b0, 1'b1, 1'b1, ldbf_pkg::MODE_RAW, 1'b1, ldbf_pkg::ONE);
                3: write_all(1'b1, 1'b0, 1'b0, 2'd3, 1'b1, 17'd40000);
                4: write_all(1'b1, 1'b1, 1'b1, 2'd3, 1'b1, 17'd1);
                default: write_all(1'b1, 1'b1, 1'b1, ldbf_pkg::MODE_RAW, 1'b1,
                                   17'($urandom_range(0, 65536)));
            endcase
            for (int n = 0; n < PER_PHASE; n++) send_obs(rand_obs());
        end
        drain();

        if (!failed) begin
            $display("landmark_dynamic_belief_filter verification clean");
        end else begin
            $display("landmark_dynamic_belief_filter verification failed");
        end
        $finish;
    end
endmodule
